>>> rtl/wsre_pkg.sv
package wsre_pkg;

  localparam int WinDepth = 16;
  localparam int PtrW     = (WinDepth > 1) ? $clog2(WinDepth) : 1;
  localparam int CntW     = $clog2(WinDepth + 1);

  localparam int OpW    = 2;
  localparam int DiffW  = 32;
  localparam int TsW    = 63;
  localparam int RateW  = 64;
  localparam int SumW   = DiffW + PtrW;
  localparam int StepW  = $clog2(RateW);

  typedef enum logic [OpW-1:0] {
    OpAdd     = 2'd0,
    OpRefresh = 2'd1,
    OpClear   = 2'd2,
    OpNop     = 2'd3
  } op_e;

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  // Advance a ring pointer with wrap at the window depth.
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(WinDepth - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

>>> rtl/wsre_div.sv
module wsre_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wsre_pkg::TsW-1:0]     rem_init_i,
  input  logic [wsre_pkg::RateW-1:0]   dvd_lo_i,
  input  logic [wsre_pkg::TsW-1:0]     divisor_i,
  output logic                         done_o,
  output logic [wsre_pkg::RateW-1:0]   quot_o
);
  import wsre_pkg::*;

  // Restoring divider, one quotient bit per cycle. The low dividend bits
  // shift out of the top of dq while quotient bits shift in at the bottom.
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepW-1:0]    cnt_q, cnt_d;
  logic [TsW-1:0]      rem_q, rem_d;
  logic [RateW-1:0]    dq_q, dq_d;
  logic [TsW-1:0]      dvs_q, dvs_d;
  logic [TsW:0]        trial;
  logic                ge;

  assign trial = {rem_q, dq_q[RateW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = rem_init_i;
      dq_d   = dvd_lo_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = TsW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[TsW-1:0];
      end
      dq_d  = {dq_q[RateW-2:0], ge};
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(RateW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

>>> rtl/windowed_share_rate_estimator.sv
// Windowed share rate estimator.
// Input channel (in_valid_i/in_ready_o) carries one command per transfer:
// add a share sample, refresh the estimate, clear history, or no-op. Every
// accepted command yields exactly one result transfer on the output channel
// (out_valid_o/out_ready_i): the held rate in MH/s and a clamp flag.
// Add and refresh run a full estimate: the ring is walked one slot a cycle
// through the sample memories (one read port, registered data), taking the
// oldest sample's timestamp and summing the difficulties of the others, then
// a bit-serial divider forms sum*2^32 / elapsed microseconds at one quotient
// bit per cycle. The 64-step divider dominates an estimate's run time.
// Clear, no-op, ignored adds and estimates with fewer than two samples go
// straight to the done step, which loads the output register; in_ready_o
// returns together with the result.
// One command is in flight at a time; in_ready_o is high whenever the block
// is idle, even while the previous result still waits in the output
// register. If the receiver stalls, the result holds and the next command
// waits in its final step until the output register frees up.
// Reset clears pointer, fill count and held rate; sample memories need no
// clearing since only slots written since the last clear are ever read.
module windowed_share_rate_estimator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wsre_pkg::OpW-1:0]      operation_i,
  input  logic                          observation_active_i,
  input  logic [wsre_pkg::DiffW-1:0]    share_difficulty_i,
  input  logic [wsre_pkg::TsW-1:0]      now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wsre_pkg::RateW-1:0]    rate_mhs_o,
  output logic                          rate_saturated_o
);
  import wsre_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSum   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  // Sample memories: one write and one read port each, read data registered.
  logic [DiffW-1:0] diff_mem [WinDepth];
  logic [TsW-1:0]   ts_mem   [WinDepth];
  logic [DiffW-1:0] diff_rd_q;
  logic [TsW-1:0]   ts_rd_q;

  logic [2:0]       state_q, state_d;
  ptr_t             wp_q, wp_d;
  cnt_t             fill_q, fill_d;
  ptr_t             addr_q, addr_d;
  cnt_t             rd_cnt_q, rd_cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_first_q, rd_first_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [TsW-1:0]   oldest_q, oldest_d;
  logic [TsW-1:0]   now_q, now_d;
  logic [RateW-1:0] last_q, last_d;
  logic             sat_q, sat_d;
  logic             out_vld_q, out_vld_d;
  logic [RateW-1:0] out_rate_q;
  logic             out_sat_q;
  logic             out_load;

  logic             accept;
  logic             add_ok;
  op_e              op;
  ptr_t             wp_c;
  cnt_t             fill_c;
  logic             rd_en;
  logic [TsW-1:0]   dur;
  logic [TsW-1:0]   sum_hi;
  logic             div_start;
  logic             div_done;
  logic [RateW-1:0] div_quot;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign op         = op_e'(operation_i);
  assign add_ok     = (op == OpAdd) && observation_active_i &&
                      (share_difficulty_i != '0);

  // Pointer and fill after an add, used to start the estimate.
  always_comb begin
    wp_c   = wp_q;
    fill_c = fill_q;
    if (add_ok) begin
      wp_c = ptr_inc(wp_q);
      if (fill_q != cnt_t'(WinDepth)) begin
        fill_c = fill_q + cnt_t'(1);
      end
    end
  end

  assign rd_en  = (state_q == StSum) && (rd_cnt_q != fill_q);
  assign dur    = now_q - oldest_q;
  assign sum_hi = TsW'(sum_q[SumW-1:DiffW]);

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    addr_d     = addr_q;
    rd_cnt_d   = rd_cnt_q;
    rd_vld_d   = 1'b0;
    rd_first_d = rd_first_q;
    sum_d      = sum_q;
    oldest_d   = oldest_q;
    now_d      = now_q;
    last_d     = last_q;
    sat_d      = sat_q;
    div_start  = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StDone;
          now_d   = now_us_i;
          if ((op == OpClear) || ((op == OpRefresh) && !observation_active_i)) begin
            wp_d   = '0;
            fill_d = '0;
            last_d = '0;
            sat_d  = 1'b0;
          end else if (add_ok || (op == OpRefresh)) begin
            wp_d   = wp_c;
            fill_d = fill_c;
            last_d = '0;
            sat_d  = 1'b0;
            if (fill_c >= cnt_t'(2)) begin
              // Oldest sample: slot 0 until the ring is full, then the pointer.
              addr_d   = (fill_c == cnt_t'(WinDepth)) ? wp_c : '0;
              rd_cnt_d = '0;
              sum_d    = '0;
              state_d  = StSum;
            end
          end
        end
      end
      StSum: begin
        if (rd_en) begin
          addr_d     = ptr_inc(addr_q);
          rd_cnt_d   = rd_cnt_q + cnt_t'(1);
          rd_vld_d   = 1'b1;
          rd_first_d = (rd_cnt_q == '0);
        end
        if (rd_vld_q) begin
          if (rd_first_q) begin
            oldest_d = ts_rd_q;
          end else begin
            sum_d = sum_q + SumW'(diff_rd_q);
          end
        end
        if (!rd_en && !rd_vld_q) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if ((oldest_q == '0) || (now_q <= oldest_q)) begin
          state_d = StDone;
        end else if (sum_hi >= dur) begin
          // Quotient needs more than 64 bits: clamp.
          last_d  = '1;
          sat_d   = 1'b1;
          state_d = StDone;
        end else begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          last_d  = div_quot;
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  wsre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (sum_hi),
    .dvd_lo_i   ({sum_q[DiffW-1:0], {(RateW - DiffW){1'b0}}}),
    .divisor_i  (dur),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Memory write on an accepted add, read while walking the window.
  always_ff @(posedge clk_i) begin
    if (accept && add_ok) begin
      diff_mem[wp_q] <= share_difficulty_i;
      ts_mem[wp_q]   <= now_us_i;
    end
    if (rd_en) begin
      diff_rd_q <= diff_mem[addr_q];
      ts_rd_q   <= ts_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      wp_q      <= '0;
      fill_q    <= '0;
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      last_q    <= '0;
      sat_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_vld_q  <= rd_vld_d;
      last_q    <= last_d;
      sat_q     <= sat_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    rd_first_q <= rd_first_d;
    sum_q      <= sum_d;
    oldest_q   <= oldest_d;
    now_q      <= now_d;
    if (out_load) begin
      out_rate_q <= last_d;
      out_sat_q  <= sat_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign rate_mhs_o       = out_rate_q;
  assign rate_saturated_o = out_sat_q;

endmodule

>>> rtl/wsre_chk.sv
module wsre_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [wsre_pkg::OpW-1:0]      operation_i,
  input logic                          observation_active_i,
  input logic [wsre_pkg::DiffW-1:0]    share_difficulty_i,
  input logic [wsre_pkg::TsW-1:0]      now_us_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [wsre_pkg::RateW-1:0]    rate_mhs_o,
  input logic                          rate_saturated_o
);
  import wsre_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rate_mhs_o) &&
    $stable(rate_saturated_o))
    else $error("stalled result changed");

  // A clamped result is all ones.
  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rate_saturated_o |-> (rate_mhs_o == {RateW{1'b1}}))
    else $error("saturated result not clamped");

  // One command in flight: ready drops after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while busy");

  // A new result appears only at the end of a command's work.
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a command in flight");

endmodule

bind windowed_share_rate_estimator wsre_chk u_wsre_chk (.*);
